// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the command pattern screen RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property checked on every clock edge outside reset.
`define CPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property that must never hold on any clock edge outside reset.
`define CPS_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define CPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPS_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ----- hdl/cps_pkg.sv -----
// Package for the command pattern screen: item and result types, the pattern
// table and small helper functions. Depends on nothing.
package cps_pkg;

  localparam int NUM_PATS = 23;
  localparam int PAT_W    = 21;
  localparam int NUM_CAT  = 7;

  // Reason category bits of the result mask.
  localparam int CAT_RECURSIVE_DELETE = 0;
  localparam int CAT_REVERSE_SHELL    = 1;
  localparam int CAT_FORK_BOMB        = 2;
  localparam int CAT_RAW_DEVICE_WRITE = 3;
  localparam int CAT_FORMAT           = 4;
  localparam int CAT_PERMISSION       = 5;
  localparam int CAT_PIPE_TO_SHELL    = 6;

  // Helper pattern kinds; any kind below NUM_CAT is a reason category.
  localparam int KIND_DD_IF  = 7;
  localparam int KIND_OF_DEV = 8;
  localparam int KIND_DD_SP  = 9;
  localparam int KIND_DD_EQ  = 10;

  // Pattern text, right-aligned: the first character sits in the highest
  // used byte.
  localparam logic [8*PAT_W-1:0] PAT_TEXT [NUM_PATS] = '{
    "rm -rf /", "rm -rf /*", "rm -rf ~", "rm -rf $HOME", "rm -rf /*.",
    "/dev/tcp", "nc -e /bin", "ncat -e /bin", "socat exec", "bash -i >&",
    ":(){ :|:& };:", ":(){:|:&};:",
    "dd if=", "mkfs",
    "chmod -R 777 /", "chmod 777 /etc/passwd",
    "curl | sh", "curl | bash", "wget | sh", "wget | bash",
    "of=/dev", "dd ", "dd="
  };

  localparam int PAT_LEN [NUM_PATS] = '{
    8, 9, 8, 12, 10,
    8, 10, 12, 10, 10,
    13, 11,
    6, 4,
    14, 21,
    9, 11, 9, 11,
    7, 3, 3
  };

  localparam int PAT_KIND [NUM_PATS] = '{
    CAT_RECURSIVE_DELETE, CAT_RECURSIVE_DELETE, CAT_RECURSIVE_DELETE,
    CAT_RECURSIVE_DELETE, CAT_RECURSIVE_DELETE,
    CAT_REVERSE_SHELL, CAT_REVERSE_SHELL, CAT_REVERSE_SHELL,
    CAT_REVERSE_SHELL, CAT_REVERSE_SHELL,
    CAT_FORK_BOMB, CAT_FORK_BOMB,
    KIND_DD_IF, CAT_FORMAT,
    CAT_PERMISSION, CAT_PERMISSION,
    CAT_PIPE_TO_SHELL, CAT_PIPE_TO_SHELL, CAT_PIPE_TO_SHELL, CAT_PIPE_TO_SHELL,
    KIND_OF_DEV, KIND_DD_SP, KIND_DD_EQ
  };

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       has_byte;
    logic       is_last;
  } cps_item_t;

  typedef struct packed {
    logic               blocked;
    logic [NUM_CAT-1:0] reason_mask;
    logic [2:0]         reason_count;
  } cps_result_t;

  // Character k of pattern i; positions past the end read as NUL, which
  // never matches because a NUL byte ends the text before matching.
  function automatic logic [7:0] pat_char(input int i, input int k);
    if (k < PAT_LEN[i]) begin
      return PAT_TEXT[i][8*(PAT_LEN[i]-1-k) +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic [2:0] popcount7(input logic [NUM_CAT-1:0] v);
    logic [2:0] cnt;
    cnt = 3'd0;
    for (int b = 0; b < NUM_CAT; b++) begin
      cnt = cnt + {2'b00, v[b]};
    end
    return cnt;
  endfunction

endpackage

// ----- hdl/cps_matcher.sv -----
// Shift-and matcher of the command pattern screen: per-command match state
// and the result of the command on its last item. Depends on cps_pkg.
module cps_matcher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  cps_pkg::cps_item_t  item_i,
  output cps_pkg::cps_result_t result_o
);
  import cps_pkg::*;

  logic [PAT_W-1:0]   pm_q [NUM_PATS];
  logic [PAT_W-1:0]   pm_d [NUM_PATS];
  logic [PAT_W-1:0]   prev_sh [NUM_PATS];
  logic [PAT_W-1:0]   nxt [NUM_PATS];
  logic [NUM_PATS-1:0] hit;

  logic [NUM_CAT-1:0] cat_q, cat_d, cat_hit, cat_u, cat_e;
  logic ddif_q, ddif_d, ddif_u, ddif_e;
  logic ddsp_q, ddsp_d, ddsp_u, ddsp_e;
  logic ddeq_q, ddeq_d, ddeq_u, ddeq_e;
  logic dwsp_q, dwsp_d, dwsp_u, dwsp_e;
  logic dweq_q, dweq_d, dweq_u, dweq_e;
  logic term_q, term_d;
  logic hit_ddif, hit_ofdev, hit_ddsp, hit_ddeq;
  logic take, raw;
  logic [NUM_CAT-1:0] mask;

  // A byte is matched unless it is the NUL terminator or follows one.
  assign take = item_i.has_byte && !term_q && (item_i.cmd_byte != 8'h00);

  always_comb begin
    for (int i = 0; i < NUM_PATS; i++) begin
      prev_sh[i] = {pm_q[i][PAT_W-2:0], 1'b1};
    end
  end

  always_comb begin
    cat_hit   = '0;
    hit_ddif  = 1'b0;
    hit_ofdev = 1'b0;
    hit_ddsp  = 1'b0;
    hit_ddeq  = 1'b0;
    for (int i = 0; i < NUM_PATS; i++) begin
      for (int k = 0; k < PAT_W; k++) begin
        nxt[i][k] = (item_i.cmd_byte == pat_char(i, k)) && prev_sh[i][k];
      end
      hit[i] = nxt[i][PAT_LEN[i]-1];
      if (PAT_KIND[i] < NUM_CAT) begin
        cat_hit[PAT_KIND[i]] = cat_hit[PAT_KIND[i]] | hit[i];
      end else if (PAT_KIND[i] == KIND_DD_IF) begin
        hit_ddif = hit_ddif | hit[i];
      end else if (PAT_KIND[i] == KIND_OF_DEV) begin
        hit_ofdev = hit_ofdev | hit[i];
      end else if (PAT_KIND[i] == KIND_DD_SP) begin
        hit_ddsp = hit_ddsp | hit[i];
      end else begin
        hit_ddeq = hit_ddeq | hit[i];
      end
    end
  end

  // State after this byte; an "of=/dev" only counts against anchors that
  // were already seen before it.
  assign cat_u  = cat_q | cat_hit;
  assign ddif_u = ddif_q | hit_ddif;
  assign ddsp_u = ddsp_q | hit_ddsp;
  assign ddeq_u = ddeq_q | hit_ddeq;
  assign dwsp_u = dwsp_q | (hit_ofdev && ddsp_q);
  assign dweq_u = dweq_q | (hit_ofdev && ddeq_q);

  assign cat_e  = take ? cat_u  : cat_q;
  assign ddif_e = take ? ddif_u : ddif_q;
  assign ddsp_e = take ? ddsp_u : ddsp_q;
  assign ddeq_e = take ? ddeq_u : ddeq_q;
  assign dwsp_e = take ? dwsp_u : dwsp_q;
  assign dweq_e = take ? dweq_u : dweq_q;

  assign raw = ddif_e && (ddsp_e ? dwsp_e : (ddeq_e && dweq_e));

  always_comb begin
    mask = cat_e;
    mask[CAT_RAW_DEVICE_WRITE] = mask[CAT_RAW_DEVICE_WRITE] | raw;
  end

  assign result_o.blocked      = |mask;
  assign result_o.reason_mask  = mask;
  assign result_o.reason_count = popcount7(mask);

  always_comb begin
    pm_d   = pm_q;
    cat_d  = cat_q;
    ddif_d = ddif_q;
    ddsp_d = ddsp_q;
    ddeq_d = ddeq_q;
    dwsp_d = dwsp_q;
    dweq_d = dweq_q;
    term_d = term_q;
    if (step_i) begin
      if (item_i.is_last) begin
        for (int i = 0; i < NUM_PATS; i++) begin
          pm_d[i] = '0;
        end
        cat_d  = '0;
        ddif_d = 1'b0;
        ddsp_d = 1'b0;
        ddeq_d = 1'b0;
        dwsp_d = 1'b0;
        dweq_d = 1'b0;
        term_d = 1'b0;
      end else begin
        if (item_i.has_byte && (item_i.cmd_byte == 8'h00)) begin
          term_d = 1'b1;
        end
        if (take) begin
          pm_d   = nxt;
          cat_d  = cat_u;
          ddif_d = ddif_u;
          ddsp_d = ddsp_u;
          ddeq_d = ddeq_u;
          dwsp_d = dwsp_u;
          dweq_d = dweq_u;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PATS; i++) begin
        pm_q[i] <= '0;
      end
      cat_q  <= '0;
      ddif_q <= 1'b0;
      ddsp_q <= 1'b0;
      ddeq_q <= 1'b0;
      dwsp_q <= 1'b0;
      dweq_q <= 1'b0;
      term_q <= 1'b0;
    end else begin
      pm_q   <= pm_d;
      cat_q  <= cat_d;
      ddif_q <= ddif_d;
      ddsp_q <= ddsp_d;
      ddeq_q <= ddeq_d;
      dwsp_q <= dwsp_d;
      dweq_q <= dweq_d;
      term_q <= term_d;
    end
  end

endmodule

// ----- hdl/command_pattern_screen.sv -----
// Command pattern screen: an input transfer reaches its result through the input
// register, then the result register; one byte is taken every cycle unless a last
// item waits on a full result register, by the shift-and update of all 23 patterns.
// An asynchronous active-low reset empties both registers and clears the
// per-command match state; the block is ready in the first cycle after reset.
// Depends on cps_pkg, cps_matcher and assert_macros.svh.
`include "assert_macros.svh"
module command_pattern_screen (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] cmd_byte_i,
  input  logic       has_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       blocked_o,
  output logic [6:0] reason_mask_o,
  output logic [2:0] reason_count_o
);
  import cps_pkg::*;

  // Input register. Each accepted item sits here until it can retire; the
  // matcher advances its state on the same edge at which the item retires.
  logic        in_vld_q, in_vld_d;
  cps_item_t   in_q, in_d;

  // Result register. Only items marked last produce a result.
  logic        out_vld_q, out_vld_d;
  cps_result_t out_q, out_d;
  cps_result_t mres;

  // The held item may retire when it yields no result, or when the result
  // register is empty or being drained in this cycle.
  logic adv;
  assign adv = in_vld_q && (!in_q.is_last || !out_vld_q || out_ready_i);

  // A new transfer is taken whenever the input register frees up.
  assign in_ready_o = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    in_d     = in_q;
    if (adv) begin
      in_vld_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      in_vld_d         = 1'b1;
      in_d.cmd_byte    = cmd_byte_i;
      in_d.has_byte    = has_byte_i;
      in_d.is_last     = is_last_i;
    end
  end

  cps_matcher u_matcher (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (in_q),
    .result_o (mres)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (adv && in_q.is_last) begin
      out_vld_d = 1'b1;
      out_d     = mres;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o    = out_vld_q;
  assign blocked_o      = out_q.blocked;
  assign reason_mask_o  = out_q.reason_mask;
  assign reason_count_o = out_q.reason_count;

  // A stalled item in the input register must still be there next cycle.
  `CPS_ASSERT(a_in_hold, clk_i, rst_ni, in_vld_q && !adv |=> in_vld_q, "input item lost")
  // A result appears only after a last item has retired.
  `CPS_ASSERT(a_out_src, clk_i, rst_ni, $rose(out_vld_q) |-> $past(adv && in_q.is_last), "result without a last item")
  // The count always agrees with the mask it reports.
  `CPS_ASSERT(a_count, clk_i, rst_ni, out_vld_q |-> (out_q.reason_count == 3'($countones(out_q.reason_mask))), "reason count mismatch")
  // A last item never retires over a pending result that is not drained.
  `CPS_NEVER(a_no_ovwr, clk_i, rst_ni, adv && in_q.is_last && out_vld_q && !out_ready_i, "result overwritten")

endmodule
